### design/sdi_pkg.sv
package sdi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_LOOP55 = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD2   = 4'd5,
    PH_CMD3   = 4'd6,
    PH_CMD9   = 4'd7,
    PH_CMD7   = 4'd8,
    PH_APP55  = 4'd9,
    PH_ACMD6  = 4'd10,
    PH_CMD13  = 4'd11,
    PH_DONE   = 4'd12
  } phase_t;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT    = 1'b0;
  localparam logic CFG_VOLTAGE_WINDOW = 1'b1;

  localparam logic [15:0] RETRY_LIMIT_RST    = 16'd10000;
  localparam logic [23:0] VOLTAGE_WINDOW_RST = 24'hFF8000;

  // request kinds
  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  // response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_LONG  = 2'd2;
  localparam logic [1:0] RK_NOXFR = 2'd3;

  localparam logic [31:0] CMD0_CODE   = 32'hD500_0000;
  localparam logic [31:0] CMD2_CODE   = 32'hD501_0002;
  localparam logic [31:0] CMD3_CODE   = 32'hD501_0003;
  localparam logic [31:0] ACMD6_CODE  = 32'hD501_0006;
  localparam logic [31:0] CMD7_CODE   = 32'hD501_0007;
  localparam logic [31:0] CMD8_CODE   = 32'hD501_0008;
  localparam logic [31:0] CMD9_CODE   = 32'hD501_0009;
  localparam logic [31:0] CMD13_CODE  = 32'hD501_000D;
  localparam logic [31:0] ACMD41_CODE = 32'hD501_0029;
  localparam logic [31:0] CMD55_CODE  = 32'hD501_0037;
  localparam logic [31:0] NOTICE_CODE = 32'hC101_0000;

  localparam logic [31:0] CMD8_PATTERN = 32'h0000_01AA;
  localparam logic [31:0] HCS_BIT      = 32'h4000_0000;
  localparam logic [31:0] BUS_WIDTH_4  = 32'h0000_0002;
  localparam logic [6:0]  STATE_TRAN   = 7'd4;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] retry_count;
    logic        is_high_capacity;
    logic [15:0] relative_addr;
  } sdi_state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [31:0] command_code;
    logic [31:0] command_argument;
    logic [1:0]  response_kind;
    logic        delay_first;
    logic        done_res;
    logic        success;
    logic        high_capacity;
    logic [15:0] card_address;
    logic [15:0] retries_used;
  } sdi_result_t;

endpackage

### design/sdi_step.sv
module sdi_step
  import sdi_pkg::*;
(
  input  sdi_state_t  state,
  input  logic [15:0] retry_limit,
  input  logic [23:0] voltage_window,
  input  logic        req_type,
  input  logic [31:0] response_word,
  output sdi_state_t  state_nxt,
  output sdi_result_t result
);

  logic [15:0] retry_inc;
  logic [31:0] rca_arg;

  assign retry_inc = state.retry_count + 16'd1;

  always_comb begin
    state_nxt = state;
    result    = '0;

    if (req_type == REQ_START) begin
      state_nxt.phase            = PH_CMD0;
      state_nxt.retry_count      = '0;
      state_nxt.is_high_capacity = 1'b0;
      state_nxt.relative_addr    = '0;
      result.cmd_valid    = 1'b1;
      result.command_code = CMD0_CODE;
      result.response_kind = RK_NONE;
    end else begin
      case (state.phase)
        PH_CMD0: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = CMD8_CODE;
          result.command_argument = CMD8_PATTERN;
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_CMD8;
        end
        PH_CMD8: begin
          state_nxt.is_high_capacity = (response_word == CMD8_PATTERN);
          result.cmd_valid = 1'b1;
          if (state.retry_count < retry_limit) begin
            result.command_code  = CMD55_CODE;
            result.response_kind = RK_SHORT;
            state_nxt.phase      = PH_LOOP55;
          end else begin
            result.command_code  = CMD2_CODE;
            result.response_kind = RK_LONG;
            state_nxt.phase      = PH_CMD2;
          end
        end
        PH_LOOP55: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = ACMD41_CODE;
          result.command_argument = {8'h00, voltage_window}
                                  | (state.is_high_capacity ? HCS_BIT : 32'h0);
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_ACMD41;
        end
        PH_ACMD41: begin
          result.cmd_valid = 1'b1;
          if (response_word[31]) begin
            result.command_code  = CMD2_CODE;
            result.response_kind = RK_LONG;
            state_nxt.phase      = PH_CMD2;
          end else begin
            // card still busy: count the attempt and wait before the next one
            state_nxt.retry_count = retry_inc;
            result.delay_first    = 1'b1;
            if (retry_inc < retry_limit) begin
              result.command_code  = CMD55_CODE;
              result.response_kind = RK_SHORT;
              state_nxt.phase      = PH_LOOP55;
            end else begin
              result.command_code  = CMD2_CODE;
              result.response_kind = RK_LONG;
              state_nxt.phase      = PH_CMD2;
            end
          end
        end
        PH_CMD2: begin
          result.cmd_valid     = 1'b1;
          result.command_code  = CMD3_CODE;
          result.response_kind = RK_SHORT;
          state_nxt.phase      = PH_CMD3;
        end
        PH_CMD3: begin
          state_nxt.relative_addr = response_word[31:16];
          result.cmd_valid        = 1'b1;
          result.command_code     = CMD9_CODE;
          // CMD3 moves the new RCA straight into the CMD9 argument
          result.command_argument = {response_word[31:16], 16'h0000};
          result.response_kind    = RK_LONG;
          state_nxt.phase         = PH_CMD9;
        end
        PH_CMD9: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = CMD7_CODE;
          result.command_argument = rca_arg;
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_CMD7;
        end
        PH_CMD7: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = CMD55_CODE;
          result.command_argument = rca_arg;
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_APP55;
        end
        PH_APP55: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = ACMD6_CODE;
          result.command_argument = BUS_WIDTH_4;
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_ACMD6;
        end
        PH_ACMD6: begin
          result.cmd_valid        = 1'b1;
          result.command_code     = CMD13_CODE;
          result.command_argument = rca_arg;
          result.response_kind    = RK_SHORT;
          state_nxt.phase         = PH_CMD13;
        end
        PH_CMD13: begin
          result.done_res = 1'b1;
          if (response_word[15:9] == STATE_TRAN) begin
            result.success = 1'b1;
            if (state.is_high_capacity) begin
              result.cmd_valid     = 1'b1;
              result.command_code  = NOTICE_CODE;
              result.response_kind = RK_NOXFR;
            end
          end
          state_nxt.phase = PH_DONE;
        end
        default: begin
          // idle or finished: response is dropped, state holds
        end
      endcase
    end

    result.high_capacity = state_nxt.is_high_capacity;
    result.card_address  = state_nxt.relative_addr;
    result.retries_used  = state_nxt.retry_count;
  end

  assign rca_arg = {state.relative_addr, 16'h0000};

endmodule

### design/sd_card_init_sequencer.sv
// A result appears on out_* in the cycle after its input transaction is accepted.
// Throughput: one item per cycle; the input side stalls only in reset or while
// a result waits in the output register and out_tready is low.
// The phase decode and command select sit between the state and output registers.
// Synchronous active-low reset: phase idle, counters and RCA cleared,
// retry_limit = 10000, voltage_window = 0xFF8000, output register empty.
module sd_card_init_sequencer
  import sdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] response_word
  input  logic         in_tuser,   // [0] req_type
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] command_code, [63:32] command_argument, [64] delay_first, [65] done_res,
  // [66] success, [67] high_capacity, [83:68] card_address, [99:84] retries_used,
  // [103:100] zero
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser,  // [0] cmd_valid, [2:1] response_kind
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_wdata
);

  logic [15:0] retry_limit_r;
  logic [23:0] voltage_window_r;
  sdi_state_t  state_r, state_nxt;
  sdi_result_t result_r, result_nxt;
  logic        out_valid_r;
  logic        in_fire;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  sdi_step u_step (
    .state          (state_r),
    .retry_limit    (retry_limit_r),
    .voltage_window (voltage_window_r),
    .req_type       (in_tuser),
    .response_word  (in_tdata),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r    <= RETRY_LIMIT_RST;
      voltage_window_r <= VOLTAGE_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_LIMIT:    retry_limit_r    <= cfg_wdata[15:0];
        CFG_VOLTAGE_WINDOW: voltage_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= PH_IDLE;
      state_r.retry_count      <= '0;
      state_r.is_high_capacity <= 1'b0;
      state_r.relative_addr    <= '0;
      out_valid_r              <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {result_r.response_kind, result_r.cmd_valid};
  assign out_tdata  = {4'b0000,
                       result_r.retries_used,
                       result_r.card_address,
                       result_r.high_capacity,
                       result_r.success,
                       result_r.done_res,
                       result_r.delay_first,
                       result_r.command_argument,
                       result_r.command_code};

endmodule

### design/sdi_checker.sv
module sdi_checker
  import sdi_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // every accepted transaction yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted transaction");

  // a waiting result blocks the input side
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result stalled");

  // start restarts at CMD0 with cleared card state
  a_start_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_START) |=>
      out_tuser[0] && (out_tdata[31:0] == CMD0_CODE) && (out_tdata[99:67] == 33'd0))
    else $error("start did not yield a clean CMD0");

  // without a command the command fields are zero
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[64:0] == 65'd0) && (out_tuser[2:1] == RK_NONE))
    else $error("command fields set without a command");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (.*);
